### src/vatb_pkg.sv
// ----------------------------------------------------------------------------
// vatb_pkg
// Shared types and constants for the vertex affine transform and bounding box.
// ----------------------------------------------------------------------------
package vatb_pkg;

   localparam int AXES        = 3;
   localparam int COORD_W     = 32;
   localparam int COEF_W      = 16;
   localparam int ROW_W       = 48;
   localparam int FRAC_SHIFT  = 12;
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;

   localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

   localparam logic [ROW_W-1:0] ROW_X_RESET = 48'h0000_0000_1000;
   localparam logic [ROW_W-1:0] ROW_Y_RESET = 48'h0000_1000_0000;
   localparam logic [ROW_W-1:0] ROW_Z_RESET = 48'h1000_0000_0000;

   typedef enum logic [2:0] {
      REG_ROW_X    = 3'd0,
      REG_ROW_Y    = 3'd1,
      REG_ROW_Z    = 3'd2,
      REG_OFFSET_X = 3'd3,
      REG_OFFSET_Y = 3'd4,
      REG_OFFSET_Z = 3'd5
   } reg_index_type;

   typedef logic [AXES-1:0][COORD_W-1:0] vec_type;

   typedef struct packed {
      logic [AXES-1:0][ROW_W-1:0]   row;
      logic [AXES-1:0][COORD_W-1:0] offset;
   } cfg_type;

endpackage

### src/vatb_req_if.sv
// ----------------------------------------------------------------------------
// vatb_req_if
// Vertex channel: one vertex word and its start flag.
// ----------------------------------------------------------------------------
interface vatb_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] in_x;
   logic [31:0] in_y;
   logic [31:0] in_z;
   logic        start_mesh;

   modport source (output valid, output in_x, output in_y, output in_z,
                   output start_mesh, input ready);
   modport sink   (input valid, input in_x, input in_y, input in_z,
                   input start_mesh, output ready);
endinterface

### src/vatb_rsp_if.sv
// ----------------------------------------------------------------------------
// vatb_rsp_if
// Result channel: transformed vertex, current box and saturation flag.
// ----------------------------------------------------------------------------
interface vatb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_x;
   logic [31:0] out_y;
   logic [31:0] out_z;
   logic [31:0] box_min_x;
   logic [31:0] box_min_y;
   logic [31:0] box_min_z;
   logic [31:0] box_max_x;
   logic [31:0] box_max_y;
   logic [31:0] box_max_z;
   logic        saturated;

   modport source (output valid, output out_x, output out_y, output out_z,
                   output box_min_x, output box_min_y, output box_min_z,
                   output box_max_x, output box_max_y, output box_max_z,
                   output saturated, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z,
                   input box_min_x, input box_min_y, input box_min_z,
                   input box_max_x, input box_max_y, input box_max_z,
                   input saturated, output ready);
endinterface

### src/vertex_affine_transform_bbox_top.sv
// ----------------------------------------------------------------------------
// vertex_affine_transform_bbox_top
// Affine vertex transform with a running bounding box.
// ----------------------------------------------------------------------------
// The block takes one vertex per clock cycle while the result channel is not
// stalled: the vertex is captured in an input register, and the transform of
// all three axes (three 16 by 32 bit multiplies per axis, their sum, the floor
// shift, the offset add and the clamp) is done in one pass into the result
// register, which also captures the updated bounding box. The result register
// and the input register are separate stages, so a new vertex is accepted
// while a finished word still waits on the result channel, as long as the
// input register is empty. The box needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module vertex_affine_transform_bbox_top (
   input  logic                            clock,
   input  logic                            reset,
   vatb_req_if.sink                        req_if,
   vatb_rsp_if.source                      rsp_if,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [vatb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [vatb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [vatb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   vatb_pkg::cfg_type   cfg;

   logic                s1_valid_ff;
   vatb_pkg::vec_type   s1_vertex_ff;
   logic                s1_start_ff;
   logic                advance;

   vatb_pkg::vec_type   result;
   logic [vatb_pkg::AXES-1:0] clamped;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   vatb_pkg::vec_type   out_ff;
   logic                sat_ff;
   vatb_pkg::vec_type   box_low;
   vatb_pkg::vec_type   box_high;

   vatb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign advance      = s1_valid_ff & (~rsp_valid_ff | rsp_if.ready);
   assign req_if.ready = ~s1_valid_ff | advance;
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid & req_if.ready) begin
         s1_vertex_ff <= {req_if.in_z, req_if.in_y, req_if.in_x};
         s1_start_ff  <= req_if.start_mesh;
      end
   end

   for (genvar a = 0; a < vatb_pkg::AXES; a++) begin : g_axis
      vatb_axis u_axis (
         .vertex  (s1_vertex_ff),
         .row     (cfg.row[a]),
         .offset  (cfg.offset[a]),
         .result  (result[a]),
         .clamped (clamped[a])
      );
   end

   vatb_box u_box (
      .clock (clock),
      .reset (reset),
      .load  (advance),
      .start (s1_start_ff),
      .value (result),
      .low   (box_low),
      .high  (box_high)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
         sat_ff <= |clamped;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_x     = out_ff[0];
   assign rsp_if.out_y     = out_ff[1];
   assign rsp_if.out_z     = out_ff[2];
   assign rsp_if.box_min_x = box_low[0];
   assign rsp_if.box_min_y = box_low[1];
   assign rsp_if.box_min_z = box_low[2];
   assign rsp_if.box_max_x = box_high[0];
   assign rsp_if.box_max_y = box_high[1];
   assign rsp_if.box_max_z = box_high[2];
   assign rsp_if.saturated = sat_ff;

   a_box_holds_vertex: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ($signed(box_low[0]) <= $signed(out_ff[0])) &&
         ($signed(box_low[1]) <= $signed(out_ff[1])) &&
         ($signed(box_low[2]) <= $signed(out_ff[2])) &&
         ($signed(box_high[0]) >= $signed(out_ff[0])) &&
         ($signed(box_high[1]) >= $signed(out_ff[1])) &&
         ($signed(box_high[2]) >= $signed(out_ff[2])))
      else $error("box does not contain the current vertex");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && sat_ff) |->
         (out_ff[0] == vatb_pkg::COORD_MAX) || (out_ff[0] == vatb_pkg::COORD_MIN) ||
         (out_ff[1] == vatb_pkg::COORD_MAX) || (out_ff[1] == vatb_pkg::COORD_MIN) ||
         (out_ff[2] == vatb_pkg::COORD_MAX) || (out_ff[2] == vatb_pkg::COORD_MIN))
      else $error("saturation flag without a clamped coordinate");

   a_stage_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff && $stable(s1_vertex_ff))
      else $error("stalled vertex lost from the input stage");

   a_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> $past(s1_valid_ff))
      else $error("result word without a vertex in the input stage");

endmodule

### src/vatb_csr.sv
// ----------------------------------------------------------------------------
// vatb_csr
// Register file for the transform rows and offsets, written over the APB port.
// ----------------------------------------------------------------------------
module vatb_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [vatb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [vatb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [vatb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output vatb_pkg::cfg_type                  cfg
);

   vatb_pkg::cfg_type       cfg_ff;
   vatb_pkg::cfg_type       cfg_in;
   vatb_pkg::reg_index_type index;
   logic                    write;

   assign index      = vatb_pkg::reg_index_type'(csr_paddr[5:3]);
   assign write      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (index)
            vatb_pkg::REG_ROW_X:    cfg_in.row[0]    = csr_pwdata[47:0];
            vatb_pkg::REG_ROW_Y:    cfg_in.row[1]    = csr_pwdata[47:0];
            vatb_pkg::REG_ROW_Z:    cfg_in.row[2]    = csr_pwdata[47:0];
            vatb_pkg::REG_OFFSET_X: cfg_in.offset[0] = csr_pwdata[31:0];
            vatb_pkg::REG_OFFSET_Y: cfg_in.offset[1] = csr_pwdata[31:0];
            vatb_pkg::REG_OFFSET_Z: cfg_in.offset[2] = csr_pwdata[31:0];
            default:                cfg_in           = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         vatb_pkg::REG_ROW_X:    csr_prdata = {16'h0, cfg_ff.row[0]};
         vatb_pkg::REG_ROW_Y:    csr_prdata = {16'h0, cfg_ff.row[1]};
         vatb_pkg::REG_ROW_Z:    csr_prdata = {16'h0, cfg_ff.row[2]};
         vatb_pkg::REG_OFFSET_X: csr_prdata = {32'h0, cfg_ff.offset[0]};
         vatb_pkg::REG_OFFSET_Y: csr_prdata = {32'h0, cfg_ff.offset[1]};
         vatb_pkg::REG_OFFSET_Z: csr_prdata = {32'h0, cfg_ff.offset[2]};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row[0]  <= vatb_pkg::ROW_X_RESET;
         cfg_ff.row[1]  <= vatb_pkg::ROW_Y_RESET;
         cfg_ff.row[2]  <= vatb_pkg::ROW_Z_RESET;
         cfg_ff.offset  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/vatb_axis.sv
// ----------------------------------------------------------------------------
// vatb_axis
// One output coordinate: dot product of a coefficient row with the vertex,
// floor shift, translation and clamp to signed 32 bits.
// ----------------------------------------------------------------------------
module vatb_axis (
   input  vatb_pkg::vec_type                  vertex,
   input  logic [vatb_pkg::ROW_W-1:0]         row,
   input  logic [vatb_pkg::COORD_W-1:0]       offset,
   output logic [vatb_pkg::COORD_W-1:0]       result,
   output logic                               clamped
);

   logic signed [47:0] prod [vatb_pkg::AXES];
   logic signed [49:0] sum;
   logic signed [37:0] shifted;
   logic signed [38:0] total;

   always_comb begin
      for (int k = 0; k < vatb_pkg::AXES; k++) begin
         prod[k] = $signed(row[16*k +: 16]) * $signed(vertex[k]);
      end
   end

   assign sum     = 50'(prod[0]) + 50'(prod[1]) + 50'(prod[2]);
   assign shifted = sum[49:12];
   assign total   = 39'(shifted) + 39'($signed(offset));

   always_comb begin
      clamped = (total[38:31] != 8'h00) && (total[38:31] != 8'hFF);
      if (!clamped) begin
         result = total[31:0];
      end else if (total[38]) begin
         result = vatb_pkg::COORD_MIN;
      end else begin
         result = vatb_pkg::COORD_MAX;
      end
   end

endmodule

### src/vatb_box.sv
// ----------------------------------------------------------------------------
// vatb_box
// Running per-axis minimum and maximum of the transformed vertices.
// ----------------------------------------------------------------------------
module vatb_box (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              start,
   input  vatb_pkg::vec_type value,
   output vatb_pkg::vec_type low,
   output vatb_pkg::vec_type high
);

   vatb_pkg::vec_type low_ff;
   vatb_pkg::vec_type low_in;
   vatb_pkg::vec_type high_ff;
   vatb_pkg::vec_type high_in;
   vatb_pkg::vec_type low_base;
   vatb_pkg::vec_type high_base;

   always_comb begin
      for (int i = 0; i < vatb_pkg::AXES; i++) begin
         low_base[i]  = start ? vatb_pkg::COORD_MAX : low_ff[i];
         high_base[i] = start ? vatb_pkg::COORD_MIN : high_ff[i];
         low_in[i]    = ($signed(value[i]) < $signed(low_base[i])) ? value[i] : low_base[i];
         high_in[i]   = ($signed(value[i]) > $signed(high_base[i])) ? value[i] : high_base[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= {vatb_pkg::AXES{vatb_pkg::COORD_MAX}};
         high_ff <= {vatb_pkg::AXES{vatb_pkg::COORD_MIN}};
      end else if (load) begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   assign low  = low_ff;
   assign high = high_ff;

endmodule
